[src/sstk_pkg.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter: shared definitions
// Widths, codes, defaults and the controller state type used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package sstk_pkg;

   // Default table geometry
   localparam int MAX_ENTRIES_DEFAULT = 64;
   localparam int KEY_BITS_DEFAULT    = 32;

   // Fixed field widths
   localparam int DATA_BITS = 32;
   localparam int CAP_BITS  = 7;

   // Count saturation value
   localparam logic [DATA_BITS-1:0] COUNT_MAX = '1;

   // Item action code
   localparam logic ACT_QUERY = 1'b1;

   // Register map
   localparam int                      CSR_ADDR_BITS     = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ADDR_CAPACITY = 2'd0;
   localparam logic [CAP_BITS-1:0]      CAPACITY_RESET    = 7'd64;

   // Controller sequence
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

[src/sstk_if.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter: channel interfaces
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sstk_req_if;
   import sstk_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [DATA_BITS-1:0] key;

   modport source (output valid, action, key, input ready);
   modport sink   (input valid, action, key, output ready);
endinterface

interface sstk_rsp_if;
   import sstk_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [DATA_BITS-1:0] count;
   logic [DATA_BITS-1:0] error_bound;
   logic                 evicted;
   logic [DATA_BITS-1:0] evicted_key;

   modport source (output valid, found, count, error_bound, evicted, evicted_key,
                   input ready);
   modport sink   (input valid, found, count, error_bound, evicted, evicted_key,
                   output ready);
endinterface

`default_nettype wire

[src/sstk_csr.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter: register block
// APB-style slave holding the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module sstk_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [sstk_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [sstk_pkg::DATA_BITS-1:0]     pwdata,
   output logic      [sstk_pkg::DATA_BITS-1:0]     prdata,
   output logic                                   pready,
   output logic      [sstk_pkg::CAP_BITS-1:0]      capacity
);
   import sstk_pkg::*;

   logic [CAP_BITS-1:0] cap_ff, cap_in;
   logic                wr_xfer;

   // No wait states
   assign pready  = 1'b1;
   assign wr_xfer = psel && penable && pwrite && pready;

   // Capacity register update
   always_comb begin
      cap_in = cap_ff;
      if (wr_xfer && paddr == CSR_ADDR_CAPACITY) begin
         cap_in = pwdata[CAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      if (paddr == CSR_ADDR_CAPACITY) begin
         prdata = DATA_BITS'(cap_ff);
      end
   end

   assign capacity = cap_ff;

endmodule

`default_nettype wire

[src/sstk_ram.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter: entry memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sstk_ram #(
   parameter int Depth = 64,
   parameter int Width = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_array [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/sstk_ctrl.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter: scan and update controller
// Scans the filled part of the entry memory for a key hit and the oldest
// least-count entry, then writes back at most one entry and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module sstk_ctrl #(
   parameter int MaxEntries = sstk_pkg::MAX_ENTRIES_DEFAULT,
   parameter int KeyBits    = sstk_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   sstk_req_if.sink                                       req,
   sstk_rsp_if.source                                     rsp,
   input  wire logic [sstk_pkg::CAP_BITS-1:0]             capacity,
   output logic                                           mem_we,
   output logic      [$clog2(MaxEntries)-1:0]             mem_waddr,
   output logic      [KeyBits+3*sstk_pkg::DATA_BITS-1:0]  mem_wdata,
   output logic                                           mem_re,
   output logic      [$clog2(MaxEntries)-1:0]             mem_raddr,
   input  wire logic [KeyBits+3*sstk_pkg::DATA_BITS-1:0]  mem_rdata
);
   import sstk_pkg::*;

   localparam int IdxBits   = $clog2(MaxEntries);
   localparam int FillBits  = $clog2(MaxEntries + 1);
   localparam int CmpBits   = (FillBits > CAP_BITS) ? FillBits : CAP_BITS;
   localparam int EntryBits = KeyBits + 3 * DATA_BITS;

   state_type state_ff, state_in;

   // Item under work
   logic                 action_ff, action_in;
   logic [KeyBits-1:0]   key_ff, key_in;

   // Table bookkeeping
   logic [FillBits-1:0]  fill_ff, fill_in;
   logic [FillBits-1:0]  scan_cnt_ff, scan_cnt_in;
   logic                 pend_ff, pend_in;
   logic [IdxBits-1:0]   pend_idx_ff, pend_idx_in;
   logic [DATA_BITS-1:0] stamp_ff, stamp_in;

   // Hit tracker
   logic                 hit_vld_ff, hit_vld_in;
   logic [IdxBits-1:0]   hit_idx_ff, hit_idx_in;
   logic [DATA_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [DATA_BITS-1:0] hit_err_ff, hit_err_in;

   // Victim tracker: least count, then oldest stamp, then lowest index
   logic                 min_vld_ff, min_vld_in;
   logic [IdxBits-1:0]   min_idx_ff, min_idx_in;
   logic [DATA_BITS-1:0] min_cnt_ff, min_cnt_in;
   logic [DATA_BITS-1:0] min_ord_ff, min_ord_in;
   logic [KeyBits-1:0]   min_key_ff, min_key_in;

   // Response register
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [DATA_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [DATA_BITS-1:0] rsp_err_ff, rsp_err_in;
   logic                 rsp_ev_ff, rsp_ev_in;
   logic [DATA_BITS-1:0] rsp_evk_ff, rsp_evk_in;

   logic                 out_free;
   logic [KeyBits-1:0]   rd_key;
   logic [DATA_BITS-1:0] rd_cnt, rd_err, rd_ord;
   logic [CmpBits-1:0]   cap_ext, eff_cap;
   logic                 below_cap;
   logic [DATA_BITS-1:0] hit_next, min_next;

   // Entry layout: key, count, error, stamp
   assign rd_key = mem_rdata[EntryBits-1 -: KeyBits];
   assign rd_cnt = mem_rdata[3*DATA_BITS-1 -: DATA_BITS];
   assign rd_err = mem_rdata[2*DATA_BITS-1 -: DATA_BITS];
   assign rd_ord = mem_rdata[DATA_BITS-1:0];

   // Effective capacity: zero reads as one, clipped to the table depth
   assign cap_ext = CmpBits'(capacity);
   always_comb begin
      if (capacity == '0) begin
         eff_cap = CmpBits'(1);
      end else if (cap_ext > CmpBits'(MaxEntries)) begin
         eff_cap = CmpBits'(MaxEntries);
      end else begin
         eff_cap = cap_ext;
      end
   end
   assign below_cap = CmpBits'(fill_ff) < eff_cap;

   // Saturating increments
   assign hit_next = (hit_cnt_ff == COUNT_MAX) ? COUNT_MAX : hit_cnt_ff + 1'b1;
   assign min_next = (min_cnt_ff == COUNT_MAX) ? COUNT_MAX : min_cnt_ff + 1'b1;

   assign out_free = !rsp_vld_ff || rsp.ready;

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      key_in       = key_ff;
      fill_in      = fill_ff;
      scan_cnt_in  = scan_cnt_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      stamp_in     = stamp_ff;
      hit_vld_in   = hit_vld_ff;
      hit_idx_in   = hit_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      hit_err_in   = hit_err_ff;
      min_vld_in   = min_vld_ff;
      min_idx_in   = min_idx_ff;
      min_cnt_in   = min_cnt_ff;
      min_ord_in   = min_ord_ff;
      min_key_in   = min_key_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evk_in   = rsp_evk_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = scan_cnt_ff[IdxBits-1:0];
      req.ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               action_in   = req.action;
               key_in      = KeyBits'(req.key);
               scan_cnt_in = '0;
               hit_vld_in  = 1'b0;
               min_vld_in  = 1'b0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle over the filled entries
            if (scan_cnt_ff != fill_ff) begin
               mem_re      = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_cnt_ff[IdxBits-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DECIDE;
            end
            // Evaluate the entry that returned this cycle
            if (pend_ff) begin
               if (!hit_vld_ff && rd_key == key_ff) begin
                  hit_vld_in = 1'b1;
                  hit_idx_in = pend_idx_ff;
                  hit_cnt_in = rd_cnt;
                  hit_err_in = rd_err;
               end
               if (!min_vld_ff || rd_cnt < min_cnt_ff ||
                   (rd_cnt == min_cnt_ff && rd_ord < min_ord_ff)) begin
                  min_vld_in = 1'b1;
                  min_idx_in = pend_idx_ff;
                  min_cnt_in = rd_cnt;
                  min_ord_in = rd_ord;
                  min_key_in = rd_key;
               end
            end
         end

         ST_DECIDE: begin
            // Write back and load the response once the output slot is free
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_found_in = 1'b0;
               rsp_cnt_in   = '0;
               rsp_err_in   = '0;
               rsp_ev_in    = 1'b0;
               rsp_evk_in   = '0;
               state_in     = ST_IDLE;
               if (action_ff == ACT_QUERY) begin
                  if (hit_vld_ff) begin
                     rsp_found_in = 1'b1;
                     rsp_cnt_in   = hit_cnt_ff;
                     rsp_err_in   = hit_err_ff;
                  end
               end else if (hit_vld_ff) begin
                  rsp_found_in = 1'b1;
                  rsp_cnt_in   = hit_next;
                  rsp_err_in   = hit_err_ff;
                  // A saturated count keeps its old stamp
                  if (hit_cnt_ff != COUNT_MAX) begin
                     mem_we    = 1'b1;
                     mem_waddr = hit_idx_ff;
                     mem_wdata = {key_ff, hit_next, hit_err_ff, stamp_ff};
                     stamp_in  = stamp_ff + 1'b1;
                  end
               end else if (below_cap) begin
                  mem_we     = 1'b1;
                  mem_waddr  = fill_ff[IdxBits-1:0];
                  mem_wdata  = {key_ff, DATA_BITS'(1), DATA_BITS'(0), stamp_ff};
                  fill_in    = fill_ff + 1'b1;
                  stamp_in   = stamp_ff + 1'b1;
                  rsp_cnt_in = DATA_BITS'(1);
               end else if (min_vld_ff) begin
                  mem_we     = 1'b1;
                  mem_waddr  = min_idx_ff;
                  mem_wdata  = {key_ff, min_next, min_cnt_ff, stamp_ff};
                  stamp_in   = stamp_ff + 1'b1;
                  rsp_cnt_in = min_next;
                  rsp_err_in = min_cnt_ff;
                  rsp_ev_in  = 1'b1;
                  rsp_evk_in = DATA_BITS'(min_key_ff);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         scan_cnt_ff <= '0;
         pend_ff     <= 1'b0;
         stamp_ff    <= '0;
         hit_vld_ff  <= 1'b0;
         min_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         scan_cnt_ff <= scan_cnt_in;
         pend_ff     <= pend_in;
         stamp_ff    <= stamp_in;
         hit_vld_ff  <= hit_vld_in;
         min_vld_ff  <= min_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      key_ff       <= key_in;
      pend_idx_ff  <= pend_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_cnt_ff   <= hit_cnt_in;
      hit_err_ff   <= hit_err_in;
      min_idx_ff   <= min_idx_in;
      min_cnt_ff   <= min_cnt_in;
      min_ord_ff   <= min_ord_in;
      min_key_ff   <= min_key_in;
      rsp_found_ff <= rsp_found_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_evk_ff   <= rsp_evk_in;
   end

   // Response channel
   assign rsp.valid       = rsp_vld_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.count       = rsp_cnt_ff;
   assign rsp.error_bound = rsp_err_ff;
   assign rsp.evicted     = rsp_ev_ff;
   assign rsp.evicted_key = rsp_evk_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillBits'(MaxEntries))
      else $error("fill level beyond table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= fill_ff)
      else $error("scan ran past the filled entries");

   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_DECIDE && out_free))
      else $error("entry write outside the decide step");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      fill_ff != $past(fill_ff) |-> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill level moved by more than one");

   a_stamp_write: assert property (@(posedge clock) disable iff (reset)
      stamp_ff != $past(stamp_ff) |-> $past(mem_we))
      else $error("stamp advanced without an entry write");

endmodule

`default_nettype wire

[src/space_saving_topk_counter_unit.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter unit
// Tracks up to MaxEntries heavy-hitter keys with count, error bound and stamp.
//
//   Channel  Direction  Handshake       Payload
//   req_if   in         valid/ready     action, key
//   rsp_if   out        valid/ready     found, count, error_bound, evicted,
//                                       evicted_key
//   csr      in/out     APB psel/penable capacity register at address 0
//
// Each item passes through an accept step, one memory read per filled entry,
// the read latency of the entry memory, a step to close the scan, and a
// write-back step; the single read port of the entry memory sets this.
// Reset clears the fill count, the stamp counter and sets capacity to 64;
// memory contents are not cleared, entries past the fill count are never read.
// A finished response waits in the output register while the next item is
// accepted; the write-back step holds until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module space_saving_topk_counter_unit #(
   parameter int MaxEntries = sstk_pkg::MAX_ENTRIES_DEFAULT,
   parameter int KeyBits    = sstk_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sstk_req_if.sink                                req_if,
   sstk_rsp_if.source                              rsp_if,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [sstk_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [sstk_pkg::DATA_BITS-1:0]     pwdata,
   output logic      [sstk_pkg::DATA_BITS-1:0]     prdata,
   output logic                                    pready
);
   import sstk_pkg::*;

   localparam int IdxBits   = $clog2(MaxEntries);
   localparam int EntryBits = KeyBits + 3 * DATA_BITS;

   logic [CAP_BITS-1:0]  capacity;
   logic                 mem_we, mem_re;
   logic [IdxBits-1:0]   mem_waddr, mem_raddr;
   logic [EntryBits-1:0] mem_wdata, mem_rdata;

   // Register block
   sstk_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   // Entry memory
   sstk_ram #(
      .Depth (MaxEntries),
      .Width (EntryBits)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Scan and update
   sstk_ctrl #(
      .MaxEntries (MaxEntries),
      .KeyBits    (KeyBits)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .capacity  (capacity),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire

[dv/sstk_checker.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter: scoreboard
// Watches the request, response and register ports, keeps its own copy of the
// monitored-key table, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sstk_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sstk_req_if                                     req_mon,
   sstk_rsp_if                                     rsp_mon,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic                               pready,
   input  wire logic [sstk_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [sstk_pkg::DATA_BITS-1:0]     pwdata,
   output int unsigned                             fail_count,
   output int unsigned                             outstanding
);
   import sstk_pkg::*;

   localparam int Depth = MAX_ENTRIES_DEFAULT;

   typedef struct packed {
      logic                 found;
      logic [DATA_BITS-1:0] count;
      logic [DATA_BITS-1:0] error_bound;
      logic                 evicted;
      logic [DATA_BITS-1:0] evicted_key;
   } tally_type;

   // Shadow table
   logic [DATA_BITS-1:0] slot_key   [Depth];
   logic [DATA_BITS-1:0] slot_count [Depth];
   logic [DATA_BITS-1:0] slot_error [Depth];
   logic [DATA_BITS-1:0] slot_stamp [Depth];
   bit                   slot_used  [Depth];
   int unsigned          fill;
   logic [DATA_BITS-1:0] stamp_ctr;
   logic [CAP_BITS-1:0]  capacity;

   tally_type tally_q[$];

   // Apply one request to the shadow table and return the response it earns
   function automatic tally_type tally_key(input logic act, input logic [DATA_BITS-1:0] key);
      tally_type            res;
      int                   hit;
      int                   victim;
      int unsigned          limit;
      logic [DATA_BITS-1:0] low;
      res    = '0;
      hit    = -1;
      victim = -1;
      limit  = (capacity == 0) ? 1 : ((capacity > Depth) ? Depth : capacity);
      for (int i = 0; i < Depth; i++) begin
         if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
      end
      if (act == ACT_QUERY) begin
         if (hit >= 0) begin
            res.found       = 1'b1;
            res.count       = slot_count[hit];
            res.error_bound = slot_error[hit];
         end
      end else if (hit >= 0) begin
         // hit: bump count unless saturated; stamp only moves with the count
         res.found = 1'b1;
         if (slot_count[hit] != COUNT_MAX) begin
            slot_count[hit] = slot_count[hit] + 1;
            slot_stamp[hit] = stamp_ctr;
            stamp_ctr++;
         end
         res.count       = slot_count[hit];
         res.error_bound = slot_error[hit];
      end else if (fill < limit && fill < Depth) begin
         // free slot: append
         slot_key[fill]   = key;
         slot_count[fill] = 1;
         slot_error[fill] = 0;
         slot_stamp[fill] = stamp_ctr;
         slot_used[fill]  = 1'b1;
         stamp_ctr++;
         fill++;
         res.count = 1;
      end else begin
         // full: replace least count, oldest stamp, lowest index
         for (int i = 0; i < Depth; i++) begin
            if (slot_used[i]) begin
               if (victim < 0 || slot_count[i] < slot_count[victim] ||
                   (slot_count[i] == slot_count[victim] &&
                    slot_stamp[i] < slot_stamp[victim]))
                  victim = i;
            end
         end
         if (victim >= 0) begin
            low                = slot_count[victim];
            res.evicted        = 1'b1;
            res.evicted_key    = slot_key[victim];
            slot_key[victim]   = key;
            slot_error[victim] = low;
            slot_count[victim] = (low == COUNT_MAX) ? COUNT_MAX : low + 1;
            slot_stamp[victim] = stamp_ctr;
            stamp_ctr++;
            res.count       = slot_count[victim];
            res.error_bound = low;
         end
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [DATA_BITS-1:0] want,
                                       input logic [DATA_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Track register writes and both channels
   always @(posedge clock) begin
      tally_type want;
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            slot_count[i] = '0;
            slot_error[i] = '0;
            slot_stamp[i] = '0;
            slot_used[i]  = 1'b0;
         end
         fill       = 0;
         stamp_ctr  = '0;
         capacity   = CAPACITY_RESET;
         fail_count = 0;
         tally_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_ADDR_CAPACITY)
            capacity = pwdata[CAP_BITS-1:0];
         // response transfer
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tally_q.size() == 0) begin
               $error("response transfer with no request pending");
               fail_count++;
            end else begin
               want = tally_q.pop_front();
               check_field("found", DATA_BITS'(want.found), DATA_BITS'(rsp_mon.found));
               check_field("count", want.count, rsp_mon.count);
               check_field("error_bound", want.error_bound, rsp_mon.error_bound);
               check_field("evicted", DATA_BITS'(want.evicted), DATA_BITS'(rsp_mon.evicted));
               check_field("evicted_key", want.evicted_key, rsp_mon.evicted_key);
            end
         end
         // request transfer
         if (req_mon.valid && req_mon.ready)
            tally_q.push_back(tally_key(req_mon.action, req_mon.key));
      end
      outstanding = tally_q.size();
   end

endmodule

`default_nettype wire

[dv/space_saving_topk_counter_unit_tb.sv]
// ----------------------------------------------------------------------------
// Space-saving top-k counter: testbench top
// Drives directed and random encounter/query traffic through several capacity
// settings with bursty requests and a stalling receiver; a separate scoreboard
// predicts every response, and this top reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module space_saving_topk_counter_unit_tb;
   import sstk_pkg::*;

   localparam logic ACT_ENCOUNTER = ~ACT_QUERY;
   localparam int   PoolMax       = 96;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0]     pwdata;
   logic [DATA_BITS-1:0]     prdata;
   logic                     pready;
   int unsigned              fail_count;
   int unsigned              outstanding;
   int unsigned              rsp_seen = 0;
   logic [DATA_BITS-1:0]     key_pool[PoolMax];
   int                       pool_size;

   sstk_req_if req_if ();
   sstk_rsp_if rsp_if ();

   space_saving_topk_counter_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sstk_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Count response transfers for the receiver hold-off
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) rsp_seen <= rsp_seen + 1;
   end

   // One request transfer; called and returns at a falling edge, valid left high
   task automatic send_item(input logic act, input logic [DATA_BITS-1:0] key);
      req_if.valid  <= 1'b1;
      req_if.action <= act;
      req_if.key    <= key;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every response has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // APB write of the capacity register: setup then access
   task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_CAPACITY;
      pwdata  <= DATA_BITS'(cap);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic fill_pool(input int n);
      pool_size = n;
      for (int i = 0; i < n; i++) key_pool[i] = $urandom;
   endtask

   // Mostly encounters on a skewed key pool, some queries, some stray keys
   task automatic pick_item(output logic act, output logic [DATA_BITS-1:0] key);
      int roll;
      int idx;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 1) idx = $urandom_range(0, pool_size / 6);
      else idx = $urandom_range(0, pool_size - 1);
      act = ACT_ENCOUNTER;
      key = key_pool[idx];
      if (roll < 14) begin
         act = ACT_QUERY;
      end else if (roll < 24) begin
         act = logic'($urandom_range(0, 1));
         key = $urandom;
      end
   endtask

   // Random traffic in bursts with gaps of random length
   task automatic run_phase(input int items, input int pool_n);
      int                   sent;
      int                   burst;
      int                   gap;
      logic                 act;
      logic [DATA_BITS-1:0] key;
      fill_pool(pool_n);
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && sent < items; b++) begin
            pick_item(act, key);
            send_item(act, key);
            sent++;
         end
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 90);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      drain();
   endtask

   // Receiver: stretches of steady, random and patterned stalls, plus one long hold
   initial begin
      int mode;
      int span;
      bit held;
      rsp_if.ready = 1'b0;
      held = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         for (int c = 0; c < span; c++) begin
            if (!held && rsp_seen >= 120) begin
               held = 1'b1;
               rsp_if.ready <= 1'b0;
               repeat (600) @(negedge clock);
            end
            case (mode)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= logic'($urandom_range(0, 1));
               end
               2: begin
                  rsp_if.ready <= (c % 4 == 0);
               end
               default: begin
                  rsp_if.ready <= ($urandom_range(0, 9) != 0);
               end
            endcase
            @(negedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      req_if.valid  = 1'b0;
      req_if.action = ACT_ENCOUNTER;
      req_if.key    = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      reset         = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // capacity zero acts as one: once the single entry is filled, every new key evicts it
      set_capacity(7'd0);
      send_item(ACT_QUERY,     32'h0000_0000);
      send_item(ACT_ENCOUNTER, 32'h0000_0000);
      send_item(ACT_ENCOUNTER, 32'h0000_0000);
      send_item(ACT_QUERY,     32'h0000_0000);
      send_item(ACT_ENCOUNTER, 32'hFFFF_FFFF);
      send_item(ACT_QUERY,     32'h0000_0000);
      send_item(ACT_QUERY,     32'hFFFF_FFFF);
      send_item(ACT_ENCOUNTER, 32'h5A5A_5A5A);
      drain();

      // three slots: fill, then ties on the least count go to the oldest stamp
      set_capacity(7'd3);
      send_item(ACT_ENCOUNTER, 32'h0000_0011);
      send_item(ACT_ENCOUNTER, 32'h0000_0022);
      send_item(ACT_ENCOUNTER, 32'h0000_0033);
      send_item(ACT_ENCOUNTER, 32'h0000_0022);
      send_item(ACT_ENCOUNTER, 32'h0000_0044);
      send_item(ACT_QUERY,     32'h0000_0044);
      send_item(ACT_ENCOUNTER, 32'h0000_0044);
      send_item(ACT_QUERY,     32'h0000_0033);
      send_item(ACT_ENCOUNTER, 32'h8000_0001);
      send_item(ACT_QUERY,     32'h7FFF_FFFE);
      send_item(ACT_QUERY,     32'h5A5A_5A5A);
      drain();

      // capacity above the table size clamps to the full table
      set_capacity(7'd127);
      run_phase(300, 96);

      // capacity lowered below the fill level: evict among all entries
      set_capacity(7'd5);
      run_phase(150, 20);

      set_capacity(7'd64);
      run_phase(300, 90);

      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
